@@ src/tetl_pkg.sv @@
package tetl_pkg;

  localparam int unsigned IdW   = 10;
  localparam int unsigned TimeW = 31;
  localparam int unsigned WordW = 32;
  localparam int unsigned SlotW = 6;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

endpackage

@@ src/tetl_if.sv @@
interface tetl_req_if;
  import tetl_pkg::*;

  logic             valid;
  logic             ready;
  logic [IdW-1:0]   entity_id;
  logic [TimeW-1:0] now_time;
  logic [WordW-1:0] pos_x_bits;
  logic [WordW-1:0] pos_y_bits;
  logic [WordW-1:0] heading_bits;

  modport source (
    output valid, entity_id, now_time, pos_x_bits, pos_y_bits, heading_bits,
    input  ready
  );

  modport sink (
    input  valid, entity_id, now_time, pos_x_bits, pos_y_bits, heading_bits,
    output ready
  );
endinterface

interface tetl_rsp_if;
  import tetl_pkg::*;

  logic             valid;
  logic             ready;
  logic [SlotW-1:0] slot_index;
  logic             was_hit;
  logic             took_free;
  logic [IdW-1:0]   evicted_id;

  modport source (
    output valid, slot_index, was_hit, took_free, evicted_id,
    input  ready
  );

  modport sink (
    input  valid, slot_index, was_hit, took_free, evicted_id,
    output ready
  );
endinterface

@@ src/tracked_entity_table_lru.sv @@
// Tracked-entity table, fully associative, oldest-time replacement.
// req_i (valid/ready) carries one update beat: entity id, current time and
// three raw payload words. rsp_o (valid/ready) returns one beat per update:
// the slot now holding the entity, hit and free-slot flags, and the id that
// was displaced on a miss (0 on a hit).
// Each update scans all TABLE_ENTRIES slots through one read port of the
// tag store, one slot a cycle, with a single comparator set tracking the
// first id match, the first zero-time slot and the oldest time.
// One update is in flight at a time, set by the single-port scan of the tag
// store; req_i.ready is high only between updates.
// A finished response sits in the output register; the next update may be
// accepted and scanned meanwhile, and its table write and response wait
// until the previous response beat is taken.
// Reset clears per-slot valid flags at once: an unwritten slot reads as
// id 0, time 0; id 0 hits the first unwritten slot. No clearing pass needed.
module tracked_entity_table_lru #(
  parameter int unsigned TABLE_ENTRIES = tetl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tetl_req_if.sink    req_i,
  tetl_rsp_if.source  rsp_o
);
  import tetl_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned TagW = IdW + TimeW;
  localparam int unsigned PayW = 3 * WordW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  localparam logic [CntW-1:0] CntEnd  = CntW'(TABLE_ENTRIES);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(TABLE_ENTRIES - 1);

  // tag store (id, time) and payload store
  logic [TagW-1:0] tag_mem [TABLE_ENTRIES];
  logic [PayW-1:0] pay_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic [IdxW-1:0]  cmp_idx_q;
  logic [TagW-1:0]  rd_tag_q;
  logic             rd_vld_q;

  logic [IdW-1:0]   id_q;
  logic [TimeW-1:0] now_q;
  logic [PayW-1:0]  pay_q;

  logic             hit_q, hit_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic             free_q, free_d;
  logic [IdxW-1:0]  free_idx_q, free_idx_d;
  logic [IdW-1:0]   free_id_q, free_id_d;
  logic [TimeW-1:0] min_time_q, min_time_d;
  logic [IdxW-1:0]  min_idx_q, min_idx_d;
  logic [IdW-1:0]   min_id_q, min_id_d;

  logic             rsp_valid_q, rsp_valid_d;
  logic [SlotW-1:0] rsp_slot_q;
  logic             rsp_hit_q;
  logic             rsp_free_q;
  logic [IdW-1:0]   rsp_evict_q;

  logic             req_fire;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic [IdW-1:0]   eff_id;
  logic [TimeW-1:0] eff_time;
  logic             wr_en;
  logic [IdxW-1:0]  pick_idx;
  logic [IdW-1:0]   pick_evict;

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;

  assign rd_en    = (state_q == StScan) && (cnt_q < CntEnd);
  assign rd_addr  = cnt_q[IdxW-1:0];
  assign eff_id   = rd_vld_q ? rd_tag_q[TagW-1:TimeW] : '0;
  assign eff_time = rd_vld_q ? rd_tag_q[TimeW-1:0] : '0;

  always_comb begin
    priority if (hit_q) begin
      pick_idx   = hit_idx_q;
      pick_evict = '0;
    end else if (free_q) begin
      pick_idx   = free_idx_q;
      pick_evict = free_id_q;
    end else begin
      pick_idx   = min_idx_q;
      pick_evict = min_id_q;
    end
  end

  assign wr_en = (state_q == StDone) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = rd_en;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    free_id_d   = free_id_q;
    min_time_d  = min_time_q;
    min_idx_d   = min_idx_q;
    min_id_d    = min_id_q;
    rsp_valid_d = rsp_valid_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (req_fire) begin
          state_d = StScan;
          cnt_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      StScan: begin
        if (rd_en) begin
          cnt_d = cnt_q + CntW'(1);
        end
        if (pend_q) begin
          if (!hit_q && (eff_id == id_q)) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx_q;
          end
          if (!free_q && (eff_time == '0)) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx_q;
            free_id_d  = eff_id;
          end
          if ((cmp_idx_q == '0) || (eff_time < min_time_q)) begin
            min_time_d = eff_time;
            min_idx_d  = cmp_idx_q;
            min_id_d   = eff_id;
          end
          if (cmp_idx_q == IdxLast) begin
            state_d = StDone;
          end
        end
      end
      StDone: begin
        if (wr_en) begin
          state_d     = StIdle;
          rsp_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      rsp_valid_q <= rsp_valid_d;
      if (wr_en) begin
        valid_q[pick_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    free_id_q  <= free_id_d;
    min_time_q <= min_time_d;
    min_idx_q  <= min_idx_d;
    min_id_q   <= min_id_d;
    if (req_fire) begin
      id_q  <= req_i.entity_id;
      now_q <= req_i.now_time;
      pay_q <= {req_i.pos_x_bits, req_i.pos_y_bits, req_i.heading_bits};
    end
    if (rd_en) begin
      cmp_idx_q <= rd_addr;
      rd_vld_q  <= valid_q[rd_addr];
    end
    if (wr_en) begin
      rsp_slot_q  <= SlotW'(pick_idx);
      rsp_hit_q   <= hit_q;
      rsp_free_q  <= !hit_q && free_q;
      rsp_evict_q <= pick_evict;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_tag_q <= tag_mem[rd_addr];
    end
    if (wr_en) begin
      tag_mem[pick_idx] <= {id_q, now_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pay_mem[pick_idx] <= pay_q;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.slot_index = rsp_slot_q;
  assign rsp_o.was_hit    = rsp_hit_q;
  assign rsp_o.took_free  = rsp_free_q;
  assign rsp_o.evicted_id = rsp_evict_q;

endmodule

@@ src/tetl_checker.sv @@
module tetl_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    req_valid_i,
  input logic                    req_ready_i,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input logic                    rsp_hit_i,
  input logic                    rsp_free_i,
  input logic [tetl_pkg::IdW-1:0] rsp_evict_i
);
  import tetl_pkg::*;

  // a response beat waiting must stay until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
    else $error("response beat dropped while stalled");

  // one update in flight: busy straight after a request beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted while scan running");

  // a new response only appears at the end of a scan
  a_rsp_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("response raised without a scan");

  // a hit displaces nothing and is never a free-slot fill
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_hit_i) |-> (!rsp_free_i && (rsp_evict_i == '0)))
    else $error("hit reported with eviction or free slot");

endmodule

bind tracked_entity_table_lru tetl_checker u_tetl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_hit_i   (rsp_o.was_hit),
  .rsp_free_i  (rsp_o.took_free),
  .rsp_evict_i (rsp_o.evicted_id)
);
